// ===== rtl/cpc_pkg.sv =====
package cpc_pkg;

    localparam int TABLE_LEN  = 24;
    localparam int STEP_BITS  = 5;
    localparam int ZW         = 34;
    localparam int ANG_BITS   = 16;
    localparam int FRAC_BITS  = 24;
    localparam int GAIN_BITS  = 24;

    localparam int CX_BITS     = 10;
    localparam int RADIUS_BITS = 9;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT_RADIUS = 2'd2;

    localparam logic [CX_BITS-1:0]     CENTER_RESET = 10'd300;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 9'd50;

    localparam logic [GAIN_BITS-1:0] GAIN_INV_Q24 = 24'd10188014;

    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ZW-1:0] ANG_ROUND    = 34'sd32768;

    typedef struct packed {
        logic start;
        logic rotate;
    } cordic_cmd_t;

    function automatic logic [29:0] atan_entry(input logic [STEP_BITS-1:0] idx);
        unique case (idx)
            5'd0:    return 30'h20000000;
            5'd1:    return 30'h12E4051E;
            5'd2:    return 30'h09FB385B;
            5'd3:    return 30'h051111D4;
            5'd4:    return 30'h028B0D43;
            5'd5:    return 30'h0145D7E1;
            5'd6:    return 30'h00A2F61E;
            5'd7:    return 30'h00517C55;
            5'd8:    return 30'h0028BE53;
            5'd9:    return 30'h00145F2F;
            5'd10:   return 30'h000A2F98;
            5'd11:   return 30'h000517CC;
            5'd12:   return 30'h00028BE6;
            5'd13:   return 30'h000145F3;
            5'd14:   return 30'h0000A2FA;
            5'd15:   return 30'h0000517D;
            5'd16:   return 30'h000028BE;
            5'd17:   return 30'h0000145F;
            5'd18:   return 30'h00000A30;
            5'd19:   return 30'h00000518;
            5'd20:   return 30'h0000028C;
            5'd21:   return 30'h00000146;
            5'd22:   return 30'h000000A3;
            5'd23:   return 30'h00000051;
            default: return 30'h0;
        endcase
    endfunction

endpackage

// ===== rtl/circular_point_clamp_core.sv =====
// Clamps a target point to a disc of radius limit_radius around (center_x, center_y).
// Each accepted transaction gives exactly one result transaction. A point inside or on
// the disc passes through. For a point outside, a
// single CORDIC stage does one micro-rotation per cycle, first in vectoring mode to
// find the direction angle, then in rotation mode to place the point on the circle,
// and one shared multiplier forms the squared distances ahead of it. s_tready is high
// only while the block is idle; a finished result waits in the output register, so a
// new point can be taken while it is held. Configuration writes are always accepted
// and must be issued only while the block is idle. direction_angle reports the last
// angle found for a point outside the disc, where 32768 stands for pi.
module circular_point_clamp_core #(
    parameter int  COORD_BITS   = 12,
    parameter int  CORDIC_STEPS = 16,
    localparam int IN_W         = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W        = ((2 * COORD_BITS + cpc_pkg::ANG_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_W-1:0]                   s_tdata,  // point_x, point_y
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_W-1:0]                  m_tdata,  // clamped_x, clamped_y, direction_angle
    output logic                              m_tuser,  // within_disc
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cpc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [cpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cpc_pkg::*;

    localparam int DXW = ((COORD_BITS > CX_BITS + 1) ? COORD_BITS : CX_BITS + 1) + 1;
    localparam int MB  = (DXW > GAIN_BITS + 1) ? DXW : GAIN_BITS + 1;
    localparam int PW  = DXW + MB;
    localparam int W   = (DXW + 18 > 36) ? DXW + 18 : 36;
    localparam logic signed [W-1:0] ROUND_HALF = W'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQR, ST_CMP, ST_VEC, ST_ROT, ST_FIN
    } state_t;

    state_t state_reg;

    logic [CX_BITS-1:0]     center_x_reg, center_y_reg;
    logic [RADIUS_BITS-1:0] radius_reg;

    logic signed [COORD_BITS-1:0] px_reg, py_reg, res_x_reg, res_y_reg;
    logic signed [DXW-1:0]        dx_reg, dy_reg;
    logic signed [PW-1:0]         prod_reg, dist_reg;
    logic [ANG_BITS-1:0]          held_angle_reg;
    logic                         within_reg;
    logic                         m_tvalid_reg, m_tuser_reg;
    logic [OUT_W-1:0]             m_tdata_reg;

    logic signed [COORD_BITS-1:0] s_px, s_py;
    logic signed [DXW-1:0]        dx_next, dy_next, r_ext, mul_a;
    logic signed [MB-1:0]         mul_b;
    logic signed [PW-1:0]         mul_p;
    logic                         outside, accept;

    cordic_cmd_t                  cmd;
    logic signed [W-1:0]          c_x0, c_y0, c_x, c_y, rx, ry, sum_x, sum_y;
    logic signed [ZW-1:0]         c_z0, c_z, z_round;
    logic [ANG_BITS-1:0]          ang_next;
    logic                         c_done;

    assign s_px    = s_tdata[COORD_BITS-1:0];
    assign s_py    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign dx_next = DXW'(s_px) - DXW'($signed({1'b0, center_x_reg}));
    assign dy_next = DXW'(s_py) - DXW'($signed({1'b0, center_y_reg}));
    assign r_ext   = DXW'($signed({1'b0, radius_reg}));
    assign accept  = s_tvalid && s_tready;
    assign outside = dist_reg > prod_reg;

    always_comb begin
        unique case (state_reg)
            ST_SQX: begin
                mul_a = dx_reg;
                mul_b = MB'(dx_reg);
            end
            ST_SQY: begin
                mul_a = dy_reg;
                mul_b = MB'(dy_reg);
            end
            ST_SQR: begin
                mul_a = r_ext;
                mul_b = MB'(r_ext);
            end
            ST_CMP: begin
                mul_a = r_ext;
                mul_b = MB'($signed({1'b0, GAIN_INV_Q24}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign z_round  = c_z + ANG_ROUND;
    assign ang_next = z_round[31:16];

    always_comb begin
        cmd.start  = ((state_reg == ST_CMP) && outside) || ((state_reg == ST_VEC) && c_done);
        cmd.rotate = (state_reg == ST_VEC);
        if (state_reg == ST_VEC) begin
            c_x0 = W'(prod_reg);
            c_y0 = '0;
            c_z0 = ZW'($signed(ang_next)) <<< 16;
        end else begin
            c_x0 = W'(dx_reg) <<< 16;
            c_y0 = W'(dy_reg) <<< 16;
            c_z0 = '0;
        end
    end

    cpc_cordic #(
        .W     (W),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .x0      (c_x0),
        .y0      (c_y0),
        .z0      (c_z0),
        .x_out   (c_x),
        .y_out   (c_y),
        .z_out   (c_z),
        .done    (c_done)
    );

    assign rx    = (c_x + ROUND_HALF) >>> FRAC_BITS;
    assign ry    = (c_y + ROUND_HALF) >>> FRAC_BITS;
    assign sum_x = rx + $signed(W'({1'b0, center_x_reg}));
    assign sum_y = ry + $signed(W'({1'b0, center_y_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= CENTER_RESET;
            center_y_reg <= CENTER_RESET;
            radius_reg   <= RADIUS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_CENTER_X:     center_x_reg <= cfg_data[CX_BITS-1:0];
                CFG_CENTER_Y:     center_y_reg <= cfg_data[CX_BITS-1:0];
                CFG_LIMIT_RADIUS: radius_reg   <= cfg_data[RADIUS_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_angle_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        px_reg    <= s_px;
                        py_reg    <= s_py;
                        dx_reg    <= dx_next;
                        dy_reg    <= dy_next;
                        state_reg <= ST_SQX;
                    end
                end
                ST_SQX: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQY;
                end
                ST_SQY: begin
                    dist_reg  <= prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQR;
                end
                ST_SQR: begin
                    dist_reg  <= dist_reg + prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    prod_reg <= mul_p;
                    if (outside) begin
                        within_reg <= 1'b0;
                        state_reg  <= ST_VEC;
                    end else begin
                        res_x_reg  <= px_reg;
                        res_y_reg  <= py_reg;
                        within_reg <= 1'b1;
                        state_reg  <= ST_FIN;
                    end
                end
                ST_VEC: begin
                    if (c_done) begin
                        held_angle_reg <= ang_next;
                        state_reg      <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    if (c_done) begin
                        res_x_reg <= sum_x[COORD_BITS-1:0];
                        res_y_reg <= sum_y[COORD_BITS-1:0];
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= OUT_W'({held_angle_reg, res_y_reg, res_x_reg});
                        m_tuser_reg  <= within_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

// ===== rtl/cpc_cordic.sv =====
module cpc_cordic #(
    parameter int W     = 36,
    parameter int STEPS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cpc_pkg::cordic_cmd_t            cmd,
    input  logic signed [W-1:0]             x0,
    input  logic signed [W-1:0]             y0,
    input  logic signed [cpc_pkg::ZW-1:0]   z0,
    output logic signed [W-1:0]             x_out,
    output logic signed [W-1:0]             y_out,
    output logic signed [cpc_pkg::ZW-1:0]   z_out,
    output logic                            done
);
    import cpc_pkg::*;

    localparam int NSTEP = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NSTEP - 1);

    logic signed [W-1:0]  x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 busy_reg, done_reg, rot_reg;

    logic signed [W-1:0]  xs, ys, x_step, y_step, x_load, y_load;
    logic signed [ZW-1:0] ang, z_step, z_load;
    logic                 ccw;

    always_comb begin
        xs  = x_reg >>> step_reg;
        ys  = y_reg >>> step_reg;
        ang = $signed(ZW'(atan_entry(step_reg)));
        ccw = rot_reg ? !z_reg[ZW-1] : y_reg[W-1];
        if (ccw) begin
            x_step = x_reg - ys;
            y_step = y_reg + xs;
            z_step = z_reg - ang;
        end else begin
            x_step = x_reg + ys;
            y_step = y_reg - xs;
            z_step = z_reg + ang;
        end
    end

    // Pre-rotation brings the start vector or angle into the right half plane.
    always_comb begin
        x_load = x0;
        y_load = y0;
        z_load = z0;
        if (cmd.rotate) begin
            if (z0 > QUARTER_TURN) begin
                z_load = z0 - HALF_TURN;
                x_load = -x0;
            end else if (z0 < -QUARTER_TURN) begin
                z_load = z0 + HALF_TURN;
                x_load = -x0;
            end
        end else begin
            z_load = '0;
            if (x0[W-1]) begin
                if (!y0[W-1]) begin
                    x_load = y0;
                    y_load = -x0;
                    z_load = QUARTER_TURN;
                end else begin
                    x_load = -y0;
                    y_load = x0;
                    z_load = -QUARTER_TURN;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rot_reg  <= 1'b0;
        end else begin
            done_reg <= !cmd.start && busy_reg && (step_reg == LAST_STEP);
            if (cmd.start) begin
                x_reg    <= x_load;
                y_reg    <= y_load;
                z_reg    <= z_load;
                rot_reg  <= cmd.rotate;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                x_reg    <= x_step;
                y_reg    <= y_step;
                z_reg    <= z_step;
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign done  = done_reg;

endmodule

// ===== rtl/cpc_checker.sv =====
module cpc_checker #(
    parameter int  COORD_BITS = 12,
    localparam int OUT_W      = ((2 * COORD_BITS + cpc_pkg::ANG_BITS + 7) / 8) * 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [OUT_W-1:0]               m_tdata,
    input logic                           m_tuser
);

    // A stalled result keeps its valid and its payload.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // Only one point is worked on at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while a point is in work");

    // A new result only appears when a point has just finished its work.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a point in work");

endmodule

bind circular_point_clamp_core cpc_checker #(.COORD_BITS(COORD_BITS)) u_cpc_checker (.*);

// ===== verif/tb_circular_point_clamp_core.sv =====
`timescale 1ns / 100ps

module tb_circular_point_clamp_core;
    import cpc_pkg::*;

    localparam int COORD_W = 12;
    localparam int STEPS = 16;
    localparam int DIRECTED_ROWS = 20;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam longint QUARTER = 64'sd1073741824;
    localparam longint HALF = 64'sd2147483648;
    localparam longint INV_GAIN = 64'sd10188014;
    localparam longint PIXEL_HALF = 64'sd8388608;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [15:0] angle;
        logic in_disc;
    } clamp_result_t;

    typedef struct packed {
        int px;
        int py;
        bit typed;
        int ex;
        int ey;
        int eang;
        bit ein;
    } point_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [CX_BITS-1:0] model_cx = 10'd300;
    logic [CX_BITS-1:0] model_cy = 10'd300;
    logic [RADIUS_BITS-1:0] model_radius = 9'd50;
    logic signed [15:0] model_angle = '0;

    clamp_result_t pending_clamps[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    longint atan_q32 [STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    // Center (300, 300) and radius 50 hold for the whole directed part.
    point_row_t directed_rows [DIRECTED_ROWS] = '{
        '{300, 300, 1'b1, 300, 300, 0, 1'b1},
        '{350, 300, 1'b1, 350, 300, 0, 1'b1},
        '{300, 250, 1'b1, 300, 250, 0, 1'b1},
        '{400, 300, 1'b1, 350, 300, 0, 1'b0},
        '{300, 400, 1'b1, 300, 350, 16384, 1'b0},
        '{310, 310, 1'b1, 310, 310, 16384, 1'b1},
        '{300, 200, 1'b1, 300, 250, -16384, 1'b0},
        '{0, 300, 1'b1, 250, 300, -32768, 1'b0},
        '{299, 300, 1'b1, 299, 300, -32768, 1'b1},
        '{-2048, -2048, 1'b0, 0, 0, 0, 1'b0},
        '{2047, 2047, 1'b0, 0, 0, 0, 1'b0},
        '{-2048, 2047, 1'b0, 0, 0, 0, 1'b0},
        '{2047, -2048, 1'b0, 0, 0, 0, 1'b0},
        '{-1, -1, 1'b0, 0, 0, 0, 1'b0},
        '{0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{351, 300, 1'b0, 0, 0, 0, 1'b0},
        '{330, 340, 1'b0, 0, 0, 0, 1'b0},
        '{1365, -1366, 1'b0, 0, 0, 0, 1'b0},
        '{-1366, 1365, 1'b0, 0, 0, 0, 1'b0},
        '{0, -1, 1'b0, 0, 0, 0, 1'b0}
    };

    circular_point_clamp_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic signed [15:0] direction_of(input longint dx, input longint dy);
        longint x, y, z, t, xs, ys;
        int i;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = QUARTER;
            end else begin
                x = -y;
                y = t;
                z = -QUARTER;
            end
        end
        for (i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q32[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q32[i];
            end
        end
        return 16'((z + 32768) >>> 16);
    endfunction

    function automatic void place_on_circle(input logic signed [15:0] ang, input longint r,
                                            output longint ox, output longint oy);
        longint x, y, z, xs, ys;
        int i;
        z = longint'(ang) * 65536;
        x = r * INV_GAIN;
        y = 0;
        if (z > QUARTER) begin
            z = z - HALF;
            x = -x;
        end else if (z < -QUARTER) begin
            z = z + HALF;
            x = -x;
        end
        for (i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q32[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q32[i];
            end
        end
        ox = (x + PIXEL_HALF) >>> 24;
        oy = (y + PIXEL_HALF) >>> 24;
    endfunction

    function automatic clamp_result_t predict_clamp(input logic signed [COORD_W-1:0] px,
                                                    input logic signed [COORD_W-1:0] py);
        longint dx, dy, r, rx, ry;
        clamp_result_t res;
        dx = longint'(px) - longint'(model_cx);
        dy = longint'(py) - longint'(model_cy);
        r = longint'(model_radius);
        if (dx * dx + dy * dy <= r * r) begin
            res.x = px;
            res.y = py;
            res.in_disc = 1'b1;
        end else begin
            model_angle = direction_of(dx, dy);
            place_on_circle(model_angle, r, rx, ry);
            res.x = COORD_W'(longint'(model_cx) + rx);
            res.y = COORD_W'(longint'(model_cy) + ry);
            res.in_disc = 1'b0;
        end
        res.angle = model_angle;
        return res;
    endfunction

    // Most points land around the disc so that both outcomes and the rim are hit often.
    function automatic logic [23:0] pick_point();
        int sel, span, ox, oy;
        sel = $urandom_range(99);
        span = 2 * int'(model_radius) + 3;
        ox = int'($urandom_range(2 * span)) - span;
        oy = int'($urandom_range(2 * span)) - span;
        if (sel < 5) begin
            ox = 0;
            oy = 0;
        end
        if (sel < 60) begin
            return {COORD_W'(int'(model_cy) + oy), COORD_W'(int'(model_cx) + ox)};
        end
        return 24'($urandom);
    endfunction

    task automatic offer_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                               input bit typed, input clamp_result_t typed_res);
        clamp_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_clamp(px, py);
        pending_clamps.push_back(typed ? typed_res : predicted);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_CENTER_X: model_cx = val[CX_BITS-1:0];
            CFG_CENTER_Y: model_cy = val[CX_BITS-1:0];
            CFG_LIMIT_RADIUS: model_radius = val[RADIUS_BITS-1:0];
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        clamp_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.x = m_tdata[11:0];
                got.y = m_tdata[23:12];
                got.angle = m_tdata[39:24];
                got.in_disc = m_tuser;
                if (pending_clamps.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected result x=%0d y=%0d angle=%0d within=%0b",
                                 got.x, got.y, got.angle, got.in_disc);
                    end
                    mismatch_count++;
                end else begin
                    want = pending_clamps.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch: expected x=%0d y=%0d angle=%0d within=%0b",
                                     want.x, want.y, want.angle, want.in_disc);
                            $display("          actual   x=%0d y=%0d angle=%0d within=%0b",
                                     got.x, got.y, got.angle, got.in_disc);
                        end
                        mismatch_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int k, phase;
        logic [23:0] pt;
        clamp_result_t typed_res;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < DIRECTED_ROWS; k++) begin
            typed_res.x = COORD_W'(directed_rows[k].ex);
            typed_res.y = COORD_W'(directed_rows[k].ey);
            typed_res.angle = 16'(directed_rows[k].eang);
            typed_res.in_disc = directed_rows[k].ein;
            offer_point(COORD_W'(directed_rows[k].px), COORD_W'(directed_rows[k].py),
                        directed_rows[k].typed, typed_res);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                s_tvalid <= 1'b0;
                while (pending_clamps.size() != 0) @(posedge aclk);
                case (phase)
                    1: begin
                        write_reg(CFG_CENTER_X, 10'd0);
                        write_reg(CFG_CENTER_Y, 10'd0);
                        write_reg(CFG_LIMIT_RADIUS, 10'd0);
                    end
                    2: begin
                        write_reg(CFG_CENTER_X, 10'd1023);
                        write_reg(CFG_CENTER_Y, 10'd1023);
                        write_reg(CFG_LIMIT_RADIUS, 10'h3FF);
                    end
                    4: begin
                        write_reg(CFG_CENTER_X, 10'd512);
                        write_reg(CFG_CENTER_Y, 10'd0);
                        write_reg(CFG_LIMIT_RADIUS, 10'd1);
                    end
                    6: begin
                        write_reg(CFG_CENTER_X, 10'd0);
                        write_reg(CFG_CENTER_Y, 10'd1023);
                        write_reg(CFG_LIMIT_RADIUS, 10'd511);
                    end
                    default: begin
                        write_reg(CFG_CENTER_X, 10'($urandom));
                        write_reg(CFG_CENTER_Y, 10'($urandom));
                        write_reg(CFG_LIMIT_RADIUS, 10'($urandom));
                    end
                endcase
                write_reg(CFG_SPARE_INDEX, 10'($urandom));
                cfg_valid <= 1'b0;
            end
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 69;
                end
                default: begin
                    send_idle_pct = 11;
                    recv_stall_pct = 11;
                end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                pt = pick_point();
                offer_point(pt[11:0], pt[23:12], 1'b0, typed_res);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_clamps.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && pending_clamps.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cpc_pkg.sv
rtl/cpc_cordic.sv
rtl/circular_point_clamp_core.sv
rtl/cpc_checker.sv
verif/tb_circular_point_clamp_core.sv
